// ----- rtl/assert_macros.svh -----
// assertion helpers, sampled on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ----- rtl/osf_pkg.sv -----
package osf_pkg;

  localparam int DATA_W = 32;
  localparam int CMD_W  = 2;
  localparam int CAP_W  = 5;
  localparam int LVL_W  = 5;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_COUNT = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAPACITY    = 1'b0,
    CFG_EMPTY_VALUE = 1'b1
  } cfg_reg_t;

  localparam logic [CAP_W-1:0] CAPACITY_RST = 5'd16;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] value;
  } osf_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_data;
    logic [LVL_W-1:0]         match_count;
    logic [LVL_W-1:0]         fill_level;
  } osf_out_t;

endpackage

// ----- rtl/osf_chan_if.sv -----
interface osf_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/overflow_summing_fifo_unit.sv -----
// FIFO of signed 32-bit values with a run-time capacity (1..DEPTH).
// in_ch carries {cmd, value}: write appends value, or adds it into the oldest
// entry (together with any entries beyond capacity) once the FIFO is full;
// read pops the oldest entry, or returns empty_value when empty; count
// reports how many stored entries equal value. out_ch carries one result per
// command: read_data, match_count and fill_level after the command.
// cfg_we/cfg_idx/cfg_data write capacity (index 0) or empty_value (index 1);
// write only while no command is in flight.
// A plain write, or a read or count of an empty FIFO, goes straight to the
// result; a read first waits for the registered memory read, a count walks
// every stored entry and a merging write walks the oldest entry and those
// beyond capacity. All entries sit in one memory with a single registered
// read port, which is walked one entry per cycle.
// One command is worked at a time; the next transfer is taken as soon as the
// result has moved into the output register, even if the receiver stalls it.
// A further result waits in the block until out_ch.ready frees that register.
// Reset empties the FIFO, sets capacity to 16 and empty_value to zero; memory
// contents are not cleared and need no clearing pass.
`include "assert_macros.svh"

module overflow_summing_fifo_unit #(
  parameter int DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  osf_chan_if.sink                            in_ch,
  osf_chan_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [osf_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [osf_pkg::DATA_W-1:0]          cfg_data
);
  import osf_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_SUM,
    ST_CNT,
    ST_DONE
  } state_t;

  state_t                   state_r;
  logic [AW-1:0]            head_r;
  logic [CW-1:0]            count_r;
  logic [CW-1:0]            idx_r;
  logic [CW-1:0]            mcnt_r;
  logic [CAP_W-1:0]         capacity_r;
  logic signed [DATA_W-1:0] empty_r;
  logic signed [DATA_W-1:0] val_r;
  logic signed [DATA_W-1:0] acc_r;
  logic signed [DATA_W-1:0] res_rd_r;
  logic [CW-1:0]            res_mc_r;
  logic                     out_valid_r;
  osf_out_t                 out_r;

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] mem_rdata_r;
  logic [AW-1:0]            mem_raddr;
  logic [AW-1:0]            mem_waddr;
  logic signed [DATA_W-1:0] mem_wdata;
  logic                     mem_we;

  logic                     in_fire;
  logic [CW-1:0]            ecap;
  logic                     ovf;
  logic [AW-1:0]            head_nxt;
  logic [CW-1:0]            mcnt_nxt;
  logic                     out_free;
  logic                     merge_last;

  function automatic logic [AW-1:0] slot_of(logic [AW-1:0] head, logic [CW-1:0] pos);
    logic [SW-1:0] s;
    s = SW'(head) + SW'(pos);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return AW'(s);
  endfunction

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  // clamp capacity into 1..DEPTH
  always_comb begin
    if (capacity_r == '0) begin
      ecap = CW'(1);
    end else if (int'(capacity_r) > DEPTH) begin
      ecap = CW'(DEPTH);
    end else begin
      ecap = CW'(capacity_r);
    end
  end

  assign ovf      = (count_r >= ecap);
  assign head_nxt = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
  assign mcnt_nxt = mcnt_r + ((mem_rdata_r == val_r) ? CW'(1) : CW'(0));
  assign merge_last = (state_r == ST_SUM) && (idx_r >= count_r);

  // memory port control
  always_comb begin
    mem_raddr = slot_of(head_r, idx_r);
    mem_we    = 1'b0;
    mem_waddr = head_r;
    mem_wdata = acc_r + mem_rdata_r;
    unique case (state_r)
      ST_IDLE: begin
        mem_raddr = head_r;
        if (in_fire && in_ch.data.cmd == CMD_WRITE && !ovf) begin
          mem_we    = 1'b1;
          mem_waddr = slot_of(head_r, count_r);
          mem_wdata = in_ch.data.value;
        end
      end
      ST_SUM: begin
        // last addend arrives: write merged value back into the oldest entry
        if (idx_r >= count_r) begin
          mem_we = 1'b1;
        end
      end
      ST_RD_WAIT, ST_CNT, ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      capacity_r  <= CAPACITY_RST;
      empty_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_CAPACITY:    capacity_r <= cfg_data[CAP_W-1:0];
          CFG_EMPTY_VALUE: empty_r    <= cfg_data;
          default: begin
          end
        endcase
      end

      // in completion the output register is reloaded below instead
      if (out_valid_r && out_ch.ready && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            val_r    <= in_ch.data.value;
            acc_r    <= in_ch.data.value;
            res_rd_r <= (in_ch.data.cmd == CMD_READ && count_r == '0) ? empty_r : '0;
            res_mc_r <= '0;
            mcnt_r   <= '0;
            unique case (in_ch.data.cmd)
              CMD_WRITE: begin
                if (ovf) begin
                  idx_r   <= ecap;
                  state_r <= ST_SUM;
                end else begin
                  count_r <= count_r + CW'(1);
                  state_r <= ST_DONE;
                end
              end
              CMD_READ: begin
                if (count_r == '0) begin
                  state_r  <= ST_DONE;
                end else begin
                  state_r <= ST_RD_WAIT;
                end
              end
              CMD_COUNT: begin
                if (count_r == '0) begin
                  state_r <= ST_DONE;
                end else begin
                  idx_r   <= CW'(1);
                  state_r <= ST_CNT;
                end
              end
              default: state_r <= ST_DONE;
            endcase
          end
        end
        ST_RD_WAIT: begin
          res_rd_r <= mem_rdata_r;
          head_r   <= head_nxt;
          count_r  <= count_r - CW'(1);
          state_r  <= ST_DONE;
        end
        ST_SUM: begin
          acc_r <= acc_r + mem_rdata_r;
          if (idx_r >= count_r) begin
            count_r <= ecap;
            state_r <= ST_DONE;
          end else begin
            idx_r <= idx_r + CW'(1);
          end
        end
        ST_CNT: begin
          if (idx_r == count_r) begin
            res_mc_r <= mcnt_nxt;
            state_r  <= ST_DONE;
          end else begin
            mcnt_r <= mcnt_nxt;
            idx_r  <= idx_r + CW'(1);
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_r.read_data   <= res_rd_r;
            out_r.match_count <= LVL_W'(res_mc_r);
            out_r.fill_level  <= LVL_W'(count_r);
            out_valid_r       <= 1'b1;
            state_r           <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_NEVER(a_count_range, count_r > CW'(DEPTH), "fill level above depth")
  `ASSERT_CLK(a_merge_fill, merge_last |=> (count_r == $past(ecap)), "merge left fill off capacity")
  `ASSERT_NEVER(a_no_write_in_count, mem_we && state_r == ST_CNT, "memory written during count walk")
  `ASSERT_CLK(a_result_from_done, $rose(out_valid_r) |-> $past(state_r == ST_DONE), "stray result")

endmodule
